// ===== design/interrupt_core_selector_macros.svh =====
// Assertion macros used by ics_ctrl.
`ifndef INTERRUPT_CORE_SELECTOR_MACROS_SVH
`define INTERRUPT_CORE_SELECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define ICS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ics assertion failed");
// Antecedent implies consequent in the following cycle.
`define ICS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ics assertion failed");
`else
`define ICS_ASSERT_IMP(lbl, ante, cons)
`define ICS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/ics_pkg.sv =====
`timescale 1ns / 1ps
package ics_pkg;

    localparam logic [1:0] MODE_SET_CORE = 2'd0;
    localparam logic [1:0] MODE_ADD_LOAD = 2'd1;
    localparam logic [1:0] MODE_REQUEST  = 2'd2;

    localparam logic [2:0] CLASS_NVME = 3'd3;
    localparam logic [2:0] CLASS_NIC  = 3'd4;

    localparam logic [1:0] REG_HOT_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CORES_ONLINE  = 2'd1;

    localparam int unsigned NVME_PLAIN_SPREAD = 4;
    localparam int unsigned NIC_SPREAD        = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MASK,
        S_PREP,
        S_COUNT,
        S_TOTAL,
        S_PICK,
        S_RESULT,
        S_WAIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MASK,
        OP_PREP,
        OP_COUNT,
        OP_TOTAL,
        OP_PICK,
        OP_RESULT,
        OP_NEXT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic total_zero;
        logic emit_last;
        logic single;
    } status_t;

endpackage

// ===== design/interrupt_core_selector.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// input    | in_valid / in_ready        | mode, core_index, node, temperature_milli,
//          |                            | load_increment, dev_class, uses_msix
// output   | out_valid / out_ready      | chosen_core, valid_res, last
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// Table updates finish in the cycle of their transfer. A request builds its masks
// in one scan over the N cores; a single-core class then scans them again (S_PICK)
// and offers its result. NVMe and NIC first count the set (S_COUNT, S_TOTAL), then
// offer each core after a pick scan, each next one only after the last is taken.
// Reset clears the table and restores the threshold to 85000 and the count to 16.
// A stalled output holds the request; no new transfer is taken until the last result.
module interrupt_core_selector #(
    parameter int MAX_CORES  = 16,
    parameter int MAX_SPREAD = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [3:0]         core_index,
    input  logic [2:0]         node,
    input  logic signed [18:0] temperature_milli,
    input  logic [31:0]        load_increment,
    input  logic [2:0]         dev_class,
    input  logic               uses_msix,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         chosen_core,
    output logic               valid_res,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [17:0]        cfg_data
);
    import ics_pkg::*;

    localparam int CW = $clog2(MAX_CORES + 1);

    logic [17:0]   hot_threshold_reg;
    logic [4:0]    cores_online_reg;
    logic [CW-1:0] ncores;
    cmd_t          cmd;
    status_t       status;

    // Configuration writes are always taken; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_threshold_reg <= 18'd85000;
            cores_online_reg  <= 5'd16;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_HOT_THRESHOLD)
            begin
                hot_threshold_reg <= cfg_data;
            end
            else if (cfg_index == REG_CORES_ONLINE)
            begin
                cores_online_reg <= cfg_data[4:0];
            end
        end
    end

    // A count of zero behaves as one core, and a count past the table as the
    // full table.
    always_comb
    begin
        int unsigned n;
        n = 32'(cores_online_reg);
        if (n < 32'd1)
        begin
            n = 32'd1;
        end
        if (n > 32'(MAX_CORES))
        begin
            n = 32'(MAX_CORES);
        end
        ncores = CW'(n);
    end

    ics_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (mode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ics_dp #(
        .MAX_CORES  (MAX_CORES),
        .MAX_SPREAD (MAX_SPREAD)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .mode              (mode),
        .core_index        (core_index),
        .node              (node),
        .temperature_milli (temperature_milli),
        .load_increment    (load_increment),
        .dev_class         (dev_class),
        .uses_msix         (uses_msix),
        .hot_threshold     (hot_threshold_reg),
        .ncores            (ncores),
        .chosen_core       (chosen_core),
        .valid_res         (valid_res),
        .last              (last)
    );
endmodule

// ===== design/ics_ctrl.sv =====
`timescale 1ns / 1ps
`include "interrupt_core_selector_macros.svh"
module ics_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      in_mode,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  ics_pkg::status_t status,
    output ics_pkg::cmd_t   cmd
);
    import ics_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_mode == MODE_REQUEST)
                begin
                    state_next = S_MASK;
                end
            end
            S_MASK:
            begin
                if (status.scan_last)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = status.single ? S_PICK : S_COUNT;
            end
            S_COUNT:
            begin
                if (status.scan_last)
                begin
                    state_next = S_TOTAL;
                end
            end
            S_TOTAL:
            begin
                state_next = status.total_zero ? S_WAIT : S_PICK;
            end
            S_PICK:
            begin
                if (status.scan_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_ready)
                begin
                    state_next = status.emit_last ? S_IDLE : S_PICK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op    = OP_NONE;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_ACCEPT;
                end
            end
            S_MASK:   cmd.op = OP_MASK;
            S_PREP:   cmd.op = OP_PREP;
            S_COUNT:  cmd.op = OP_COUNT;
            S_TOTAL:  cmd.op = OP_TOTAL;
            S_PICK:   cmd.op = OP_PICK;
            S_RESULT: cmd.op = OP_RESULT;
            S_WAIT:
            begin
                out_valid = 1'b1;
                if (out_ready && !status.emit_last)
                begin
                    cmd.op = OP_NEXT;
                end
            end
            default:  cmd.op = OP_NONE;
        endcase
    end

    // The input and output sides are never open together.
    `ICS_ASSERT_IMP(a_no_overlap, in_ready && out_valid, 1'b0)
    // A result that has not been taken is still offered next cycle.
    `ICS_ASSERT_NXT(a_hold_result, out_valid && !out_ready, out_valid)
    // An empty recommendation goes straight to the output.
    `ICS_ASSERT_NXT(a_empty_direct, state_reg == S_TOTAL && status.total_zero,
        out_valid && status.emit_last)
endmodule

// ===== design/ics_dp.sv =====
`timescale 1ns / 1ps
module ics_dp #(
    parameter int MAX_CORES  = 16,
    parameter int MAX_SPREAD = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ics_pkg::cmd_t                  cmd,
    output ics_pkg::status_t               status,
    input  logic [1:0]                     mode,
    input  logic [3:0]                     core_index,
    input  logic [2:0]                     node,
    input  logic signed [18:0]             temperature_milli,
    input  logic [31:0]                    load_increment,
    input  logic [2:0]                     dev_class,
    input  logic                           uses_msix,
    input  logic [17:0]                    hot_threshold,
    input  logic [$clog2(MAX_CORES+1)-1:0] ncores,
    output logic [3:0]                     chosen_core,
    output logic                           valid_res,
    output logic                           last
);
    import ics_pkg::*;

    localparam int IW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int CW = $clog2(MAX_CORES + 1);

    logic [2:0]         node_reg [MAX_CORES];
    logic [63:0]        load_reg [MAX_CORES];
    logic signed [18:0] temp_reg [MAX_CORES];

    logic [2:0]           req_node_reg;
    logic [2:0]           req_class_reg;
    logic                 req_msix_reg;
    logic [IW-1:0]        idx_reg;
    logic [MAX_CORES-1:0] match_reg, hot_reg, set_reg, taken_reg;
    logic [CW-1:0]        setcnt_reg, coolcnt_reg, total_reg, round_reg;
    logic                 found_reg, have_first_reg;
    logic [IW-1:0]        best_reg, first_reg;
    logic [63:0]          low_load_reg;
    logic [3:0]           chosen_reg;
    logic                 valid_reg, last_reg;

    logic [IW-1:0]        wr_idx, rd_idx;
    logic                 in_range;
    logic [63:0]          rd_load;
    logic [64:0]          sum;
    logic                 rd_hot;
    logic                 scan_last;
    logic [MAX_CORES-1:0] online_mask, cand, cool, elig, nic_set;
    logic                 is_nvme, is_nic, single;
    logic [CW-1:0]        total_c;
    logic                 pick_ok;

    assign wr_idx   = IW'(core_index);
    assign in_range = {28'd0, core_index} < 32'(MAX_CORES);
    assign rd_idx   = (cmd.op == OP_ACCEPT) ? wr_idx : idx_reg;
    assign rd_load  = load_reg[rd_idx];
    assign sum      = {1'b0, rd_load} + {33'd0, load_increment};
    assign rd_hot   = $signed({temp_reg[rd_idx][18], temp_reg[rd_idx]})
                      >= $signed({2'b00, hot_threshold});
    assign scan_last = ({{(32-IW){1'b0}}, idx_reg} + 32'd1) == {{(32-CW){1'b0}}, ncores};

    always_comb
    begin
        for (int i = 0; i < MAX_CORES; i++)
        begin
            online_mask[i] = CW'(i) < ncores;
        end
    end

    assign cand    = (match_reg != '0) ? match_reg : online_mask;
    assign cool    = cand & ~hot_reg;
    assign elig    = (cool != '0) ? cool : cand;
    assign nic_set = ((elig & ~MAX_CORES'(1)) != '0) ? (elig & ~MAX_CORES'(1)) : elig;
    assign is_nvme = req_class_reg == CLASS_NVME;
    assign is_nic  = req_class_reg == CLASS_NIC;
    assign single  = !is_nvme && !is_nic;
    assign pick_ok = set_reg[idx_reg] && !taken_reg[idx_reg] && !hot_reg[idx_reg];

    // Number of results: the spread limit of the class, cut to the cool members.
    always_comb
    begin
        int unsigned lim;
        int unsigned tot;
        if (is_nvme)
        begin
            if (req_msix_reg)
            begin
                lim = (32'(setcnt_reg) < 32'(MAX_SPREAD)) ? 32'(setcnt_reg) : 32'(MAX_SPREAD);
            end
            else
            begin
                lim = NVME_PLAIN_SPREAD;
            end
        end
        else
        begin
            lim = (32'(setcnt_reg) < NIC_SPREAD) ? 32'(setcnt_reg) : NIC_SPREAD;
        end
        tot = (lim < 32'(coolcnt_reg)) ? lim : 32'(coolcnt_reg);
        total_c = CW'(tot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CORES; i++)
            begin
                node_reg[i] <= '0;
                load_reg[i] <= '0;
                temp_reg[i] <= '0;
            end
        end
        else if (cmd.op == OP_ACCEPT && in_range)
        begin
            if (mode == MODE_SET_CORE)
            begin
                node_reg[wr_idx] <= node;
                temp_reg[wr_idx] <= temperature_milli;
            end
            else if (mode == MODE_ADD_LOAD)
            begin
                load_reg[wr_idx] <= sum[64] ? {64{1'b1}} : sum[63:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ACCEPT:
            begin
                req_node_reg  <= node;
                req_class_reg <= dev_class;
                req_msix_reg  <= uses_msix;
                idx_reg       <= '0;
                match_reg     <= '0;
                hot_reg       <= '0;
            end
            OP_MASK:
            begin
                match_reg[idx_reg] <= node_reg[idx_reg] == req_node_reg;
                hot_reg[idx_reg]   <= rd_hot;
                idx_reg            <= scan_last ? '0 : idx_reg + 1'b1;
            end
            OP_PREP:
            begin
                set_reg        <= is_nic ? nic_set : elig;
                taken_reg      <= '0;
                setcnt_reg     <= '0;
                coolcnt_reg    <= '0;
                round_reg      <= '0;
                found_reg      <= 1'b0;
                have_first_reg <= 1'b0;
                idx_reg        <= '0;
            end
            OP_COUNT:
            begin
                if (set_reg[idx_reg])
                begin
                    setcnt_reg <= setcnt_reg + 1'b1;
                end
                if (set_reg[idx_reg] && !hot_reg[idx_reg])
                begin
                    coolcnt_reg <= coolcnt_reg + 1'b1;
                end
                idx_reg <= scan_last ? '0 : idx_reg + 1'b1;
            end
            OP_TOTAL:
            begin
                total_reg <= total_c;
                if (total_c == '0)
                begin
                    chosen_reg <= '0;
                    valid_reg  <= 1'b0;
                    last_reg   <= 1'b1;
                end
            end
            OP_PICK:
            begin
                if (pick_ok && (!found_reg || rd_load < low_load_reg))
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= idx_reg;
                    low_load_reg <= rd_load;
                end
                if (set_reg[idx_reg] && !have_first_reg)
                begin
                    have_first_reg <= 1'b1;
                    first_reg      <= idx_reg;
                end
                idx_reg <= scan_last ? '0 : idx_reg + 1'b1;
            end
            OP_RESULT:
            begin
                valid_reg <= 1'b1;
                if (single)
                begin
                    chosen_reg <= 4'(found_reg ? best_reg : first_reg);
                    last_reg   <= 1'b1;
                end
                else
                begin
                    chosen_reg          <= 4'(best_reg);
                    last_reg            <= (round_reg + 1'b1) == total_reg;
                    taken_reg[best_reg] <= 1'b1;
                    round_reg           <= round_reg + 1'b1;
                end
            end
            OP_NEXT:
            begin
                found_reg <= 1'b0;
                idx_reg   <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign status.scan_last  = scan_last;
    assign status.total_zero = total_c == '0;
    assign status.emit_last  = last_reg;
    assign status.single     = single;

    assign chosen_core = chosen_reg;
    assign valid_res   = valid_reg;
    assign last        = last_reg;
endmodule
